// ----- design/aws_pkg.sv -----
package aws_pkg;

  localparam int WINDOW_MAX = 4096;
  localparam int FRAC_BITS  = 16;

  localparam int CODE_W = 24;
  localparam int CNT_W  = $clog2(WINDOW_MAX) + 1;
  localparam int SUM_W  = CODE_W + CNT_W - 1;
  localparam int SQR_W  = 2 * CODE_W - 1;
  localparam int SQS_W  = SQR_W + CNT_W - 1;
  localparam int SCL_W  = 24;

  // wide products, dividend and quotient of the shared units
  localparam int PROD_W = 72;
  localparam int MULB_W = 64;
  localparam int DVD_W  = PROD_W + 2 * FRAC_BITS;
  localparam int QUO_W  = 46;
  localparam int LIM_W  = 45;
  localparam int ROOT_W = 22;

  localparam logic [CNT_W-1:0] WLEN_RESET  = CNT_W'(WINDOW_MAX);
  localparam logic [SCL_W-1:0] SCALE_RESET = SCL_W'(167000);

  localparam logic [LIM_W-1:0] LIM_POS  = LIM_W'(24'h7FFFFF);
  localparam logic [LIM_W-1:0] LIM_NEG  = LIM_W'(24'h800000);
  localparam logic [LIM_W-1:0] LIM_VAR  = LIM_W'(28'hFFFFFFF);
  localparam logic [LIM_W-1:0] LIM_ROOT = LIM_W'(1) << (2 * ROOT_W);
  localparam logic [ROOT_W-1:0] ROOT_MAX = '1;
  localparam logic [27:0] VAR_MAX = '1;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    REG_CAPTURE = 2'd0,
    REG_WINDOW  = 2'd1,
    REG_SCALE   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic       ready_event;
    logic [7:0] byte_high;
    logic [7:0] byte_mid;
    logic [7:0] byte_low;
  } in_t;

  typedef struct packed {
    logic signed [23:0] max_value;
    logic signed [23:0] min_value;
    logic signed [23:0] mean_value;
    logic [27:0]        variance_value;
    logic [21:0]        rms_value;
    logic [21:0]        std_value;
  } out_t;

  // closed window handed from the accumulator to the statistics engine
  typedef struct packed {
    logic signed [CODE_W-1:0] smax;
    logic signed [CODE_W-1:0] smin;
    logic signed [SUM_W-1:0]  ssum;
    logic [SQS_W-1:0]         ssq;
    logic [CNT_W-1:0]         n;
    logic [SCL_W-1:0]         s;
  } snap_t;

  typedef struct packed {
    logic [PROD_W-1:0] num;
    logic [PROD_W-1:0] den;
    logic              fb32;
    logic              rnd;
    logic [LIM_W-1:0]  limit;
  } div_req_t;

endpackage

// ----- design/aws_front.sv -----
module aws_front import aws_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  input  logic             cap_en,
  input  logic [CNT_W-1:0] n_eff,
  input  logic [SCL_W-1:0] s_eff,
  output logic             push,
  output snap_t            push_data,
  input  logic             q_full
);

  typedef enum logic [1:0] {F_IDLE, F_SQ, F_ACC} fst_t;

  fst_t                     st_r;
  logic signed [CODE_W-1:0] x_r;
  logic [SQR_W-1:0]         sq_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [CODE_W-1:0] max_r;
  logic signed [CODE_W-1:0] min_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [SQS_W-1:0]         sqsum_r;
  logic [SQS_W-1:0]         sqsum_nxt;
  logic signed [2*CODE_W-1:0] sq_full;
  logic                     close;

  always_comb begin
    sq_full   = x_r * x_r;
    sqsum_nxt = sqsum_r + SQS_W'(sq_r);
    close     = cnt_r >= n_eff;
    in_ready  = st_r == F_IDLE;
    push      = (st_r == F_ACC) && close && !q_full;
    push_data = '{smax: max_r, smin: min_r, ssum: sum_r, ssq: sqsum_nxt,
                  n: n_eff, s: s_eff};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      sqsum_r <= '0;
    end else begin
      case (st_r)
        F_IDLE: begin
          if (in_valid && in_data.ready_event && cap_en) begin
            x_r  <= {in_data.byte_high, in_data.byte_mid, in_data.byte_low};
            st_r <= F_SQ;
          end
        end
        F_SQ: begin
          sq_r <= sq_full[SQR_W-1:0];
          if (cnt_r == '0) begin
            max_r <= x_r;
            min_r <= x_r;
          end else begin
            if (x_r > max_r) max_r <= x_r;
            if (x_r < min_r) min_r <= x_r;
          end
          sum_r <= sum_r + SUM_W'(x_r);
          cnt_r <= cnt_r + 1'b1;
          st_r  <= F_ACC;
        end
        F_ACC: begin
          if (!close) begin
            sqsum_r <= sqsum_nxt;
            st_r    <= F_IDLE;
          end else if (!q_full) begin
            // window handed over, start a fresh one
            cnt_r   <= '0;
            sum_r   <= '0;
            sqsum_r <= '0;
            st_r    <= F_IDLE;
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- design/aws_fifo.sv -----
module aws_fifo import aws_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  snap_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output snap_t pop_data
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  snap_t         mem_r [QDEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] cnt_r;

  always_comb begin
    full     = cnt_r == CW'(QDEPTH);
    valid    = cnt_r != '0;
    pop_data = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- design/aws_div.sv -----
module aws_div import aws_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  div_req_t         req,
  output logic             done,
  output logic [LIM_W-1:0] q
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dst_t;

  localparam int CNTW = $clog2(DVD_W);

  dst_t              st_r;
  div_req_t          req_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [PROD_W-1:0] rem_r;
  logic [QUO_W-1:0]  q_r;
  logic              ovf_r;
  logic [CNTW-1:0]   cnt_r;
  logic              done_r;
  logic [LIM_W-1:0]  q_out_r;

  logic [PROD_W:0]   r2;
  logic              ge;
  logic [PROD_W:0]   diff;
  logic              rnd_up;
  logic [QUO_W:0]    qr;

  always_comb begin
    r2     = {rem_r, dvd_r[DVD_W-1]};
    ge     = r2 >= {1'b0, req_r.den};
    diff   = r2 - {1'b0, req_r.den};
    rnd_up = req_r.rnd && ({rem_r, 1'b0} >= {1'b0, req_r.den});
    qr     = {1'b0, q_r} + (QUO_W + 1)'(rnd_up);
    done   = done_r;
    q      = q_out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= st_r == D_FIN;
      case (st_r)
        D_IDLE: begin
          if (start) begin
            req_r <= req;
            dvd_r <= req.fb32 ? {req.num, (2 * FRAC_BITS)'(0)}
                              : {FRAC_BITS'(0), req.num, FRAC_BITS'(0)};
            rem_r <= '0;
            q_r   <= '0;
            ovf_r <= 1'b0;
            cnt_r <= '0;
            st_r  <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= ge ? diff[PROD_W-1:0] : r2[PROD_W-1:0];
          // quotient bits beyond the register only ever mean saturation
          ovf_r <= ovf_r | q_r[QUO_W-1];
          q_r   <= {q_r[QUO_W-2:0], ge};
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(DVD_W - 1)) st_r <= D_FIN;
        end
        D_FIN: begin
          q_out_r <= (ovf_r || qr > (QUO_W + 1)'(req_r.limit)) ? req_r.limit
                                                               : qr[LIM_W-1:0];
          st_r    <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- design/aws_back.sv -----
module aws_back import aws_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  snap_t q_data,
  output logic  pop,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  typedef enum logic [4:0] {
    B_IDLE, B_DMAX, B_DMIN, B_MNS, B_DMEAN, B_MNQ, B_MSS, B_MS2, B_MNN,
    B_MVD, B_DVAR, B_DSTD, B_SQSTD, B_MRD, B_DRMS, B_SQRMS, B_OUT
  } bst_t;

  localparam int MCW = $clog2(MULB_W);

  bst_t              st_r;
  snap_t             sn_r;
  logic              busy_r;
  out_t              res_r;
  logic              out_valid_r;
  out_t              out_data_r;

  logic [PROD_W-1:0] mul_a_r;
  logic [MULB_W-1:0] mul_b_r;
  logic [PROD_W-1:0] acc_r;
  logic [MCW-1:0]    mcnt_r;
  logic [PROD_W-1:0] acc_nxt;
  logic [PROD_W-1:0] mul_a;
  logic [MULB_W-1:0] mul_b;
  logic              mul_last;

  logic [PROD_W-1:0] ns_r, nq_r, ss_r, s2_r, nn1_r, vden_r, rden_r;

  logic [LIM_W-1:0]  sv_r, sres_r, sbit_r;
  logic [LIM_W:0]    st_sum;
  logic              sge;
  logic [LIM_W-1:0]  sv_nxt, sres_nxt;
  logic [ROOT_W-1:0] root;

  logic              div_start;
  div_req_t          div_req;
  logic              div_done;
  logic [LIM_W-1:0]  div_q;

  logic              max_neg, min_neg, sum_neg, vneg;
  logic [CODE_W-1:0] max_mag, min_mag;
  logic [SUM_W-1:0]  sum_mag;
  logic [PROD_W:0]   var_diff;
  logic              is_div, is_mul;

  aws_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    max_neg  = sn_r.smax[CODE_W-1];
    min_neg  = sn_r.smin[CODE_W-1];
    sum_neg  = sn_r.ssum[SUM_W-1];
    max_mag  = max_neg ? CODE_W'(-sn_r.smax) : CODE_W'(sn_r.smax);
    min_mag  = min_neg ? CODE_W'(-sn_r.smin) : CODE_W'(sn_r.smin);
    sum_mag  = sum_neg ? SUM_W'(-sn_r.ssum) : SUM_W'(sn_r.ssum);
    var_diff = {1'b0, nq_r} - {1'b0, ss_r};
    vneg     = var_diff[PROD_W];

    acc_nxt  = mul_b_r[0] ? acc_r + mul_a_r : acc_r;
    mul_last = mcnt_r == MCW'(MULB_W - 1);

    st_sum   = {1'b0, sres_r} + {1'b0, sbit_r};
    sge      = {1'b0, sv_r} >= st_sum;
    sv_nxt   = sge ? sv_r - st_sum[LIM_W-1:0] : sv_r;
    sres_nxt = sge ? (sres_r >> 1) + sbit_r : sres_r >> 1;
    root     = sres_nxt[ROOT_W] ? ROOT_MAX : sres_nxt[ROOT_W-1:0];

    mul_a = '0;
    mul_b = '0;
    is_mul = 1'b1;
    case (st_r)
      B_MNS: begin mul_a = PROD_W'(sn_r.s);  mul_b = MULB_W'(sn_r.n); end
      B_MNQ: begin mul_a = PROD_W'(sn_r.ssq); mul_b = MULB_W'(sn_r.n); end
      B_MSS: begin mul_a = PROD_W'(sum_mag); mul_b = MULB_W'(sum_mag); end
      B_MS2: begin mul_a = PROD_W'(sn_r.s);  mul_b = MULB_W'(sn_r.s); end
      B_MNN: begin mul_a = PROD_W'(sn_r.n);  mul_b = MULB_W'(sn_r.n - 1'b1); end
      B_MVD: begin mul_a = s2_r;             mul_b = nn1_r[MULB_W-1:0]; end
      B_MRD: begin mul_a = s2_r;             mul_b = MULB_W'(sn_r.n); end
      default: is_mul = 1'b0;
    endcase

    div_req = '{num: '0, den: PROD_W'(sn_r.s), fb32: 1'b0, rnd: 1'b1,
                limit: LIM_POS};
    is_div  = 1'b1;
    case (st_r)
      B_DMAX: begin
        div_req.num   = PROD_W'(max_mag);
        div_req.limit = max_neg ? LIM_NEG : LIM_POS;
      end
      B_DMIN: begin
        div_req.num   = PROD_W'(min_mag);
        div_req.limit = min_neg ? LIM_NEG : LIM_POS;
      end
      B_DMEAN: begin
        div_req.num   = PROD_W'(sum_mag);
        div_req.den   = ns_r;
        div_req.limit = sum_neg ? LIM_NEG : LIM_POS;
      end
      B_DVAR: begin
        div_req.num   = var_diff[PROD_W-1:0];
        div_req.den   = vden_r;
        div_req.limit = LIM_VAR;
      end
      B_DSTD: begin
        div_req.num   = var_diff[PROD_W-1:0];
        div_req.den   = vden_r;
        div_req.fb32  = 1'b1;
        div_req.rnd   = 1'b0;
        div_req.limit = LIM_ROOT;
      end
      B_DRMS: begin
        div_req.num   = PROD_W'(sn_r.ssq);
        div_req.den   = rden_r;
        div_req.fb32  = 1'b1;
        div_req.rnd   = 1'b0;
        div_req.limit = LIM_ROOT;
      end
      default: is_div = 1'b0;
    endcase

    div_start = is_div && !busy_r;
    pop       = (st_r == B_IDLE) && q_valid;
    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && st_r != B_OUT) out_valid_r <= 1'b0;

      // shift-add multiplier, one multiplier bit a cycle
      if (is_mul) begin
        if (!busy_r) begin
          mul_a_r <= mul_a;
          mul_b_r <= mul_b;
          acc_r   <= '0;
          mcnt_r  <= '0;
          busy_r  <= 1'b1;
        end else begin
          acc_r   <= acc_nxt;
          mul_a_r <= mul_a_r << 1;
          mul_b_r <= mul_b_r >> 1;
          mcnt_r  <= mcnt_r + 1'b1;
        end
      end

      if (div_start) busy_r <= 1'b1;

      case (st_r)
        B_IDLE: begin
          if (q_valid) begin
            sn_r <= q_data;
            st_r <= B_DMAX;
          end
        end
        B_DMAX: begin
          if (div_done) begin
            res_r.max_value <= max_neg ? -div_q[CODE_W-1:0] : div_q[CODE_W-1:0];
            busy_r <= 1'b0;
            st_r   <= B_DMIN;
          end
        end
        B_DMIN: begin
          if (div_done) begin
            res_r.min_value <= min_neg ? -div_q[CODE_W-1:0] : div_q[CODE_W-1:0];
            busy_r <= 1'b0;
            st_r   <= B_MNS;
          end
        end
        B_MNS: begin
          if (busy_r && mul_last) begin
            ns_r <= acc_nxt; busy_r <= 1'b0; st_r <= B_DMEAN;
          end
        end
        B_DMEAN: begin
          if (div_done) begin
            res_r.mean_value <= sum_neg ? -div_q[CODE_W-1:0] : div_q[CODE_W-1:0];
            busy_r <= 1'b0;
            st_r   <= B_MNQ;
          end
        end
        B_MNQ: begin
          if (busy_r && mul_last) begin
            nq_r <= acc_nxt; busy_r <= 1'b0; st_r <= B_MSS;
          end
        end
        B_MSS: begin
          if (busy_r && mul_last) begin
            ss_r <= acc_nxt; busy_r <= 1'b0; st_r <= B_MS2;
          end
        end
        B_MS2: begin
          if (busy_r && mul_last) begin
            s2_r <= acc_nxt; busy_r <= 1'b0; st_r <= B_MNN;
          end
        end
        B_MNN: begin
          if (busy_r && mul_last) begin
            nn1_r <= acc_nxt; busy_r <= 1'b0; st_r <= B_MVD;
          end
        end
        B_MVD: begin
          if (busy_r && mul_last) begin
            vden_r <= acc_nxt; busy_r <= 1'b0; st_r <= B_DVAR;
          end
        end
        B_DVAR: begin
          if (div_done) begin
            // a negative spread only arises from a shortened window
            res_r.variance_value <= vneg ? VAR_MAX : div_q[27:0];
            busy_r <= 1'b0;
            st_r   <= B_DSTD;
          end
        end
        B_DSTD: begin
          if (div_done) begin
            sv_r   <= div_q;
            sres_r <= '0;
            sbit_r <= LIM_ROOT;
            busy_r <= 1'b0;
            st_r   <= B_SQSTD;
          end
        end
        B_SQSTD: begin
          sv_r   <= sv_nxt;
          sres_r <= sres_nxt;
          sbit_r <= sbit_r >> 2;
          if (sbit_r[0]) begin
            res_r.std_value <= vneg ? ROOT_MAX : root;
            st_r <= B_MRD;
          end
        end
        B_MRD: begin
          if (busy_r && mul_last) begin
            rden_r <= acc_nxt; busy_r <= 1'b0; st_r <= B_DRMS;
          end
        end
        B_DRMS: begin
          if (div_done) begin
            sv_r   <= div_q;
            sres_r <= '0;
            sbit_r <= LIM_ROOT;
            busy_r <= 1'b0;
            st_r   <= B_SQRMS;
          end
        end
        B_SQRMS: begin
          sv_r   <= sv_nxt;
          sres_r <= sres_nxt;
          sbit_r <= sbit_r >> 2;
          if (sbit_r[0]) begin
            res_r.rms_value <= root;
            st_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            st_r        <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- design/adc_window_statistics.sv -----
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    in_data   (in_t: event flag, three code bytes)
// out       out   out_valid / out_ready  out_data  (out_t: max, min, mean, var, rms, std)
// cfg       in    cfg_valid / cfg_ready  cfg_index, cfg_data (24 bits)
//
// a sample goes through take, square and add in the accumulator; others are dropped
// a closed window runs through the statistics engine as six 104-step divisions,
// seven 64-step shift-add products and two 23-step square roots
// two closed windows queue between the parts; with both slots full the accumulator
// holds its last sample until a slot frees; a waiting result holds the engine at B_OUT
// synchronous active-low reset; no clearing pass, items are taken once reset is released
module adc_window_statistics import aws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_idx_t    cfg_index,
  input  logic [23:0] cfg_data
);

  logic             cap_r;
  logic [CNT_W-1:0] wlen_r;
  logic [SCL_W-1:0] scale_r;
  logic [CNT_W-1:0] n_eff;
  logic [SCL_W-1:0] s_eff;

  logic  q_push, q_full, q_pop, q_valid;
  snap_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (wlen_r < CNT_W'(2))               n_eff = CNT_W'(2);
    else if (wlen_r > CNT_W'(WINDOW_MAX)) n_eff = CNT_W'(WINDOW_MAX);
    else                                  n_eff = wlen_r;
    s_eff = (scale_r == '0) ? SCL_W'(1) : scale_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= 1'b0;
      wlen_r  <= WLEN_RESET;
      scale_r <= SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAPTURE: cap_r   <= cfg_data[0];
        REG_WINDOW:  wlen_r  <= cfg_data[CNT_W-1:0];
        REG_SCALE:   scale_r <= cfg_data[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  aws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cap_en    (cap_r),
    .n_eff     (n_eff),
    .s_eff     (s_eff),
    .push      (q_push),
    .push_data (q_wdata),
    .q_full    (q_full)
  );

  aws_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  aws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_front_multi: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.ready_event && cap_r) |=> !in_ready)
    else $error("accumulator took a sample while still busy");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("window pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && !q_valid))
    else $error("window popped from an empty queue");

endmodule
